@@ rtl/gcr_pkg.sv @@
// Shared types, constants and GCR 4-to-5 coding functions for the sector encoder.
// No dependencies; used by gcr_front, gcr_serial, the top level and the bench.
`timescale 1ns / 1ps
`default_nettype none

package gcr_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DISK_ID_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_ID_SECOND = 1'b1;

  localparam logic [7:0] DISK_ID_RESET = 8'd48;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [7:0] GAP_BYTE    = 8'h55;
  localparam logic [7:0] HEADER_MARK = 8'h08;
  localparam logic [7:0] DATA_MARK   = 8'h07;
  localparam logic [7:0] HEADER_PAD  = 8'h0F;

  localparam logic [7:0] LAST_INDEX = 8'd255;

  // job kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FIRST = 2'd1;
  localparam logic [1:0] KIND_GROUP = 2'd2;
  localparam logic [1:0] KIND_LAST  = 2'd3;

  // output byte positions within a job
  localparam logic [4:0] POS_GRP0     = 5'd5;
  localparam logic [4:0] POS_GRP1     = 5'd10;
  localparam logic [4:0] POS_HDR_GAP  = 5'd15;
  localparam logic [4:0] POS_SYNC2    = 5'd24;
  localparam logic [4:0] LEN_FIRST    = 5'd29;
  localparam logic [4:0] LEN_GROUP    = 5'd5;
  localparam logic [4:0] LEN_LAST     = 5'd13;

  typedef struct packed {
    logic [1:0]  kind;
    logic [39:0] grp0;
    logic [39:0] grp1;
  } job_t;

  function automatic logic [4:0] nib_code(input logic [3:0] n);
    logic [4:0] c;
    unique case (n)
      4'h0: c = 5'h0A;
      4'h1: c = 5'h0B;
      4'h2: c = 5'h12;
      4'h3: c = 5'h13;
      4'h4: c = 5'h0E;
      4'h5: c = 5'h0F;
      4'h6: c = 5'h16;
      4'h7: c = 5'h17;
      4'h8: c = 5'h09;
      4'h9: c = 5'h19;
      4'hA: c = 5'h1A;
      4'hB: c = 5'h1B;
      4'hC: c = 5'h0D;
      4'hD: c = 5'h1D;
      4'hE: c = 5'h1E;
      4'hF: c = 5'h15;
      default: c = 5'h00;
    endcase
    return c;
  endfunction

  // four raw bytes -> 40 code bits, first byte in the MSBs
  function automatic logic [39:0] pack_group(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [7:0] d);
    return {nib_code(a[7:4]), nib_code(a[3:0]), nib_code(b[7:4]), nib_code(b[3:0]),
            nib_code(c[7:4]), nib_code(c[3:0]), nib_code(d[7:4]), nib_code(d[3:0])};
  endfunction

  function automatic logic [7:0] grp_byte(input logic [39:0] g, input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0: b = g[39:32];
      3'd1: b = g[31:24];
      3'd2: b = g[23:16];
      3'd3: b = g[15:8];
      3'd4: b = g[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/gcr_in_if.sv @@
// Request channel carrying one sector data byte with its header fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface gcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] track_number;
  logic [7:0] sector_number;

  modport source (output valid, output data_byte, output track_number,
                  output sector_number, input ready);
  modport sink (input valid, input data_byte, input track_number,
                input sector_number, output ready);
endinterface

`default_nettype wire

@@ rtl/gcr_out_if.sv @@
// Result channel carrying one byte of the encoded sector image.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface gcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] gcr_byte;
  logic       run_last;
  logic       sector_end;

  modport source (output valid, output gcr_byte, output run_last,
                  output sector_end, input ready);
  modport sink (input valid, input gcr_byte, input run_last,
                input sector_end, output ready);
endinterface

`default_nettype wire

@@ rtl/gcr_front.sv @@
// Input stage: sector position, checksum, group assembly, GCR coding into a job register.
// Depends on gcr_pkg and gcr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module gcr_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  gcr_in_if.sink                              in_ch,
  output gcr_pkg::job_t                       job,
  output logic                                job_valid,
  input  wire logic                           job_take
);
  import gcr_pkg::*;

  logic [7:0]  disk_id_first;
  logic [7:0]  disk_id_second;
  logic [7:0]  byte_index;
  logic [7:0]  data_xor;
  logic [23:0] pending_group;

  logic        accept;
  logic [7:0]  xor_new;
  logic [7:0]  hsum;
  job_t        job_next;
  logic [7:0]  data_xor_next;
  logic [23:0] pending_group_next;

  assign in_ch.ready = !job_valid || job_take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    xor_new = data_xor ^ in_ch.data_byte;
    hsum    = in_ch.sector_number ^ in_ch.track_number ^ disk_id_first ^ disk_id_second;
    job_next.kind = KIND_NONE;
    job_next.grp0 = pack_group(pending_group[23:16], pending_group[15:8],
                               pending_group[7:0], in_ch.data_byte);
    job_next.grp1 = pack_group(disk_id_second, disk_id_first, HEADER_PAD, HEADER_PAD);
    data_xor_next      = xor_new;
    pending_group_next = {pending_group[15:0], in_ch.data_byte};
    priority if (byte_index == 8'd0) begin
      job_next.kind      = KIND_FIRST;
      job_next.grp0      = pack_group(HEADER_MARK, hsum, in_ch.sector_number,
                                      in_ch.track_number);
      pending_group_next = {8'h00, DATA_MARK, in_ch.data_byte};
    end else if (byte_index == LAST_INDEX) begin
      job_next.kind      = KIND_LAST;
      job_next.grp0      = pack_group(in_ch.data_byte, xor_new, 8'h00, 8'h00);
      data_xor_next      = 8'h00;
      pending_group_next = 24'h0;
    end else if (byte_index[1:0] == 2'd2) begin
      job_next.kind      = KIND_GROUP;
      pending_group_next = 24'h0;
    end else begin
      job_next.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_id_first  <= DISK_ID_RESET;
      disk_id_second <= DISK_ID_RESET;
      byte_index     <= 8'd0;
      data_xor       <= 8'd0;
      pending_group  <= 24'h0;
      job_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DISK_ID_FIRST:  disk_id_first  <= cfg_wdata;
          CFG_DISK_ID_SECOND: disk_id_second <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        byte_index    <= byte_index + 8'd1;
        data_xor      <= data_xor_next;
        pending_group <= pending_group_next;
        job_valid     <= (job_next.kind != KIND_NONE);
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gcr_serial.sv @@
// Output stage: walks one job byte by byte into the result register.
// Depends on gcr_pkg and gcr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module gcr_serial (
  input  wire logic    clk,
  input  wire logic    rst,
  input  gcr_pkg::job_t job,
  input  wire logic    job_valid,
  output logic         job_take,
  gcr_out_if.source    out_ch
);
  import gcr_pkg::*;

  logic        busy;
  logic [1:0]  kind;
  logic [39:0] grp0;
  logic [39:0] grp1;
  logic [4:0]  pos;

  logic        step;
  logic        last_pos;
  logic        done;
  logic [4:0]  len;
  logic [4:0]  off0;
  logic [4:0]  off1;
  logic [7:0]  byte_next;

  always_comb begin
    unique case (kind)
      KIND_FIRST: len = LEN_FIRST;
      KIND_LAST:  len = LEN_LAST;
      default:    len = LEN_GROUP;
    endcase
  end

  assign step     = busy && (!out_ch.valid || out_ch.ready);
  assign last_pos = (pos == len - 5'd1);
  assign done     = step && last_pos;
  assign job_take = job_valid && (!busy || done);
  assign off0     = pos - POS_GRP0;
  assign off1     = pos - POS_GRP1;

  always_comb begin
    if (kind == KIND_FIRST) begin
      priority if (pos < POS_GRP0) begin
        byte_next = SYNC_BYTE;
      end else if (pos < POS_GRP1) begin
        byte_next = grp_byte(grp0, off0[2:0]);
      end else if (pos < POS_HDR_GAP) begin
        byte_next = grp_byte(grp1, off1[2:0]);
      end else if (pos < POS_SYNC2) begin
        byte_next = GAP_BYTE;
      end else begin
        byte_next = SYNC_BYTE;
      end
    end else begin
      if (pos < POS_GRP0) begin
        byte_next = grp_byte(grp0, pos[2:0]);
      end else begin
        byte_next = GAP_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pos          <= 5'd0;
      out_ch.valid <= 1'b0;
    end else begin
      if (job_take) begin
        busy <= 1'b1;
        pos  <= 5'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (step) begin
        pos <= pos + 5'd1;
      end
      if (step) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      kind <= job.kind;
      grp0 <= job.grp0;
      grp1 <= job.grp1;
    end
    if (step) begin
      out_ch.gcr_byte   <= byte_next;
      out_ch.run_last   <= last_pos;
      out_ch.sector_end <= last_pos && (kind == KIND_LAST);
    end
  end

endmodule

`default_nettype wire

@@ rtl/gcr_disk_sector_encoder.sv @@
// GCR disk sector encoder: 256 data bytes in, 362-byte GCR sector image out.
// Uses gcr_pkg, gcr_in_if, gcr_out_if, gcr_front and gcr_serial.
//
// in_ch takes one sector data byte per request; track_number and sector_number
// are read only on the first byte of a sector. out_ch delivers the image one
// byte per request: 29 bytes on the first data byte (sync, header groups, gap,
// sync), 5 on every group-closing byte, 13 on byte 255 (checksum group and tail
// gap), none on the others. run_last marks the last byte of each input's burst,
// sector_end the final tail byte.
// The first byte of a burst passes the job register, then the output register.
// Throughput: one output byte per cycle while out_ch is ready, set by the single
// serializer; inputs are taken one per cycle while the one-deep job register
// has room.
// Config writes (cfg_we, cfg_index, cfg_wdata) set the disk ID bytes and apply
// at the next sector header. Synchronous reset returns to the start of a
// sector with both IDs at 48 and no pending output. A stall on out_ch holds
// the output byte; the job register then fills and in_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module gcr_disk_sector_encoder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  gcr_in_if.sink                              in_ch,
  gcr_out_if.source                           out_ch
);
  import gcr_pkg::*;

  job_t job;
  logic job_valid;
  logic job_take;

  gcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take)
  );

  gcr_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

@@ tb/gcr_disk_sector_encoder_tb.sv @@
// Self-checking bench for gcr_disk_sector_encoder: sends runs of sector data bytes,
// checks every GCR image byte against an in-bench encoder, with bursty requests and stalls.
// Depends on gcr_pkg, gcr_in_if, gcr_out_if and the encoder RTL.
`timescale 1ns / 1ps

module gcr_disk_sector_encoder_tb;

  typedef struct packed {
    logic [7:0] gcr_byte;
    logic       run_last;
    logic       sector_end;
  } image_byte_t;

  class sector_image_board;
    image_byte_t due[$];
    logic [7:0]  byte_pos;
    logic [7:0]  xor_acc;
    logic [23:0] held;
    logic [7:0]  id_first;
    logic [7:0]  id_second;
    int          errors;

    function new();
      byte_pos  = 8'd0;
      xor_acc   = 8'd0;
      held      = 24'd0;
      id_first  = gcr_pkg::DISK_ID_RESET;
      id_second = gcr_pkg::DISK_ID_RESET;
      errors    = 0;
    endfunction

    function void set_id(input logic [gcr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
      if (idx == gcr_pkg::CFG_DISK_ID_FIRST) id_first = v;
      else if (idx == gcr_pkg::CFG_DISK_ID_SECOND) id_second = v;
    endfunction

    function logic [4:0] gcr5(input logic [3:0] n);
      logic [4:0] c;
      case (n)
        4'h0: c = 5'h0A;
        4'h1: c = 5'h0B;
        4'h2: c = 5'h12;
        4'h3: c = 5'h13;
        4'h4: c = 5'h0E;
        4'h5: c = 5'h0F;
        4'h6: c = 5'h16;
        4'h7: c = 5'h17;
        4'h8: c = 5'h09;
        4'h9: c = 5'h19;
        4'hA: c = 5'h1A;
        4'hB: c = 5'h1B;
        4'hC: c = 5'h0D;
        4'hD: c = 5'h1D;
        4'hE: c = 5'h1E;
        default: c = 5'h15;
      endcase
      return c;
    endfunction

    function void add_byte(input logic [7:0] v);
      image_byte_t e;
      e.gcr_byte   = v;
      e.run_last   = 1'b0;
      e.sector_end = 1'b0;
      due.push_back(e);
    endfunction

    function void add_fill(input logic [7:0] v, input int count);
      for (int i = 0; i < count; i++) add_byte(v);
    endfunction

    function void add_group(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d);
      logic [39:0] bits;
      bits = {gcr5(a[7:4]), gcr5(a[3:0]), gcr5(b[7:4]), gcr5(b[3:0]),
              gcr5(c[7:4]), gcr5(c[3:0]), gcr5(d[7:4]), gcr5(d[3:0])};
      for (int i = 4; i >= 0; i--) add_byte(bits[8*i +: 8]);
    endfunction

    // one accepted request -> the image bytes it releases
    function void encode_request(input logic [7:0] d, input logic [7:0] trk,
                                 input logic [7:0] sec);
      int          size_at_start;
      image_byte_t tail;
      size_at_start = due.size();
      xor_acc = xor_acc ^ d;
      if (byte_pos == 8'd0) begin
        add_fill(gcr_pkg::SYNC_BYTE, 5);
        add_group(gcr_pkg::HEADER_MARK, sec ^ trk ^ id_first ^ id_second, sec, trk);
        add_group(id_second, id_first, gcr_pkg::HEADER_PAD, gcr_pkg::HEADER_PAD);
        add_fill(gcr_pkg::GAP_BYTE, 9);
        add_fill(gcr_pkg::SYNC_BYTE, 5);
        held = {8'h00, gcr_pkg::DATA_MARK, d};
      end else if (byte_pos == gcr_pkg::LAST_INDEX) begin
        add_group(d, xor_acc, 8'h00, 8'h00);
        add_fill(gcr_pkg::GAP_BYTE, 8);
        tail = due.pop_back();
        tail.sector_end = 1'b1;
        due.push_back(tail);
        xor_acc = 8'd0;
        held    = 24'd0;
      end else if (byte_pos[1:0] == 2'd2) begin
        add_group(held[23:16], held[15:8], held[7:0], d);
        held = 24'd0;
      end else begin
        held = {held[15:0], d};
      end
      byte_pos = byte_pos + 8'd1;
      if (due.size() > size_at_start) begin
        tail = due.pop_back();
        tail.run_last = 1'b1;
        due.push_back(tail);
      end
    endfunction

    function void compare_byte(input logic [7:0] g, input logic rl, input logic se);
      image_byte_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected byte %02h run_last %0b sector_end %0b", $time, g, rl, se);
        errors++;
      end else begin
        e = due.pop_front();
        if (g !== e.gcr_byte) begin
          $display("%0t: gcr_byte expected %02h got %02h", $time, e.gcr_byte, g);
          errors++;
        end
        if (rl !== e.run_last) begin
          $display("%0t: run_last expected %0b got %0b", $time, e.run_last, rl);
          errors++;
        end
        if (se !== e.sector_end) begin
          $display("%0t: sector_end expected %0b got %0b", $time, e.sector_end, se);
          errors++;
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we;
  logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gcr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gcr_in_if  in_ch ();
  gcr_out_if out_ch ();

  gcr_disk_sector_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sector_image_board board;
  int burst_left = 0;
  int sent = 0;
  int stall_count = 0;
  int stall_mode = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("gcr_disk_sector_encoder_tb: done, errors");
    $finish;
  end

  // receiver: switches between no stall, random stall and 1-in-4 ready
  always @(negedge clk) begin
    stall_count = stall_count + 1;
    if (stall_count % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (stall_count % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.compare_byte(out_ch.gcr_byte, out_ch.run_last, out_ch.sector_end);
    end
  end

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input logic [7:0] d, input logic [7:0] trk,
                              input logic [7:0] sec);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= d;
    in_ch.track_number  <= trk;
    in_ch.sector_number <= sec;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.encode_request(d, trk, sec);
    burst_left--;
    sent++;
    @(negedge clk);
  endtask

  // header values apply only where the request opens a sector
  task automatic send_run(input int count, input logic [7:0] hdr_trk,
                          input logic [7:0] hdr_sec);
    logic [7:0] d;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: d = 8'h00;
        1: d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      if (sent % 256 == 0) send_request(d, hdr_trk, hdr_sec);
      else send_request(d, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_ids(input logic [7:0] id1, input logic [7:0] id2);
    cfg_we    <= 1'b1;
    cfg_index <= gcr_pkg::CFG_DISK_ID_FIRST;
    cfg_wdata <= id1;
    @(negedge clk);
    board.set_id(gcr_pkg::CFG_DISK_ID_FIRST, id1);
    cfg_index <= gcr_pkg::CFG_DISK_ID_SECOND;
    cfg_wdata <= id2;
    @(negedge clk);
    board.set_id(gcr_pkg::CFG_DISK_ID_SECOND, id2);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    board = new();
    cfg_we              = 1'b0;
    cfg_index           = gcr_pkg::CFG_DISK_ID_FIRST;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.track_number  = 8'h00;
    in_ch.sector_number = 8'h00;
    out_ch.ready        = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sector 0 with reset IDs: all nibble codes, header field extremes,
    // header fields varied mid-sector
    send_request(8'h00, 8'hFF, 8'h00);
    for (int i = 1; i < 24; i++) begin
      if (i < 16) send_request(8'(i * 17), (i % 2) ? 8'h00 : 8'hFF, (i % 2) ? 8'hFF : 8'h00);
      else send_request(8'($urandom), 8'($urandom), 8'($urandom));
    end

    // ID writes mid-sector: the data stream is unaffected
    wait_idle();
    write_ids(8'h00, 8'hFF);
    send_run(96, 8'h00, 8'h00);

    wait_idle();
    write_ids(8'hFF, 8'h00);
    send_run(40, 8'hFF, 8'hFF);

    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (board.errors == 0) begin
      $display("gcr_disk_sector_encoder_tb: done, clean");
    end else begin
      $display("gcr_disk_sector_encoder_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ gcr_disk_sector_encoder.f @@
rtl/gcr_pkg.sv
rtl/gcr_in_if.sv
rtl/gcr_out_if.sv
rtl/gcr_front.sv
rtl/gcr_serial.sv
rtl/gcr_disk_sector_encoder.sv
tb/gcr_disk_sector_encoder_tb.sv
